[rtl/ibbl_pkg.sv]
// shared types, constants and divide helpers for the in-place luma box blur
`timescale 1ns / 1ps

package ibbl_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;

    localparam logic [CFG_INDEX_W-1:0] CFG_BLUR_MODE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

    localparam logic [11:0] RESET_FRAME_WIDTH  = 12'd640;
    localparam logic [12:0] RESET_FRAME_HEIGHT = 13'd480;

    // result queue
    localparam int MAX_RESULTS = 4;
    localparam int PUSH_CNT_W  = $clog2(MAX_RESULTS + 1);
    localparam int FIFO_DEPTH  = 16;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    // reciprocals: floor(s * m / 2^n) == floor(s / d) over the used sum ranges
    localparam logic [11:0] DIV9_RECIP = 12'd3641;  // 2^15 / 9, rounded up
    localparam logic [9:0]  DIV3_RECIP = 10'd683;   // 2^11 / 3, rounded up

    typedef enum logic [2:0] {
        ROW_HORIZ,   // 1x3 mode, every line
        ROW_TOP,     // 3x3 mode, first line: 1x3 rule, outputs kept for the next line
        ROW_FILL,    // 3x3 mode, second line: inputs stored only
        ROW_MID,     // 3x3 mode, middle line: finishes the line above
        ROW_BOTTOM   // 3x3 mode, last line: finishes the line above and itself
    } t_row_kind;

    typedef struct packed {
        t_row_kind kind;
        logic      first;     // column 0
        logic      second;    // column 1
        logic      last;      // column w-1
        logic      last_row;  // line h-1
    } t_item_ctl;

    typedef struct packed {
        logic [7:0] pixel;
        logic       eol;
        logic       eof;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [PUSH_CNT_W-1:0]        count;
        t_result [MAX_RESULTS-1:0]    entry;
    } t_push;

    typedef struct packed {
        logic s1_valid;
        logic s2_valid;
    } t_pipe_status;

    function automatic logic [7:0] div9(input logic [11:0] s);
        logic [23:0] prod;
        prod = 24'(s) * 24'(DIV9_RECIP);
        return prod[22:15];
    endfunction

    function automatic logic [7:0] div3(input logic [9:0] s);
        logic [19:0] prod;
        prod = 20'(s) * 20'(DIV3_RECIP);
        return prod[18:11];
    endfunction

endpackage

[rtl/ibbl_line_ram.sv]
// single-port-write, single-port-read line memory, read-first, registered read
`timescale 1ns / 1ps

module ibbl_line_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/ibbl_blur_core.sv]
// window registers, sum stage and left-neighbour recurrence of the blur
`timescale 1ns / 1ps

module ibbl_blur_core #(
    parameter int ADDR_W = 11
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  ibbl_pkg::t_item_ctl      i_ctl,
    input  logic [ADDR_W-1:0]        i_col,
    input  logic [7:0]               i_pixel,
    input  logic [7:0]               i_ao_rdata,
    input  logic [7:0]               i_pi_rdata,
    output logic                     o_ao_we,
    output logic [ADDR_W-1:0]        o_ao_waddr,
    output logic [7:0]               o_ao_wdata,
    output ibbl_pkg::t_push          o_push,
    output ibbl_pkg::t_pipe_status   o_status
);

    // last two inputs of the raster
    logic [7:0] r_x1, r_x2;

    // stage 1
    logic                r_s1_valid;
    ibbl_pkg::t_item_ctl r_s1_ctl;
    logic [ADDR_W-1:0]   r_s1_col;
    logic [7:0]          r_s1_x, r_s1_prev, r_s1_prev2;
    logic [7:0]          r_a1, r_a2, r_p1;
    logic                r_byp_valid;
    logic [7:0]          r_byp_data;

    // stage 2
    logic                r_s2_valid;
    ibbl_pkg::t_item_ctl r_s2_ctl;
    logic [ADDR_W-1:0]   r_s2_col;
    logic [7:0]          r_s2_x, r_s2_prev, r_s2_p0, r_s2_p1;
    logic [10:0]         r_s2_sum9;
    logic [8:0]          r_s2_sum3;
    logic [7:0]          r_left, r_tail;

    // second write of a line end
    logic                r_dw_valid;
    logic [ADDR_W-1:0]   r_dw_addr;
    logic [7:0]          r_dw_data;

    logic [7:0]  a0;
    logic [10:0] n_sum9;
    logic [8:0]  n_sum3;

    logic        is_nine, keeps_line;
    logic [7:0]  o3, ot, o9, main_pix, end_pix;
    logic        v_main, v_main_end, v_tail, v_tail_end;
    logic        main_we;
    logic        n_byp_valid;
    ibbl_pkg::t_push push;

    // stage 1: sum of the eight taps that do not depend on the left output
    always_comb begin
        a0 = r_byp_valid ? r_byp_data : i_ao_rdata;
        n_sum9 = 11'(r_a2) + 11'(r_a1) + 11'(a0) + 11'(r_p1) + 11'(i_pi_rdata)
               + 11'(r_s1_prev2) + 11'(r_s1_prev) + 11'(r_s1_x);
        n_sum3 = 9'(r_s1_prev) + 9'(r_s1_x);
    end

    // stage 2: recurrence and result list
    always_comb begin
        is_nine    = (r_s2_ctl.kind == ibbl_pkg::ROW_MID) ||
                     (r_s2_ctl.kind == ibbl_pkg::ROW_BOTTOM);
        keeps_line = is_nine || (r_s2_ctl.kind == ibbl_pkg::ROW_TOP);

        o3 = r_s2_ctl.second ? r_s2_prev : ibbl_pkg::div3(10'(r_left) + 10'(r_s2_sum3));
        ot = r_s2_ctl.second ? r_s2_prev : ibbl_pkg::div3(10'(r_tail) + 10'(r_s2_sum3));
        o9 = r_s2_ctl.second ? r_s2_p1   : ibbl_pkg::div9(12'(r_left) + 12'(r_s2_sum9));

        main_pix = is_nine ? o9 : o3;
        end_pix  = is_nine ? r_s2_p0 : r_s2_x;

        v_main     = r_s2_valid && !r_s2_ctl.first && (r_s2_ctl.kind != ibbl_pkg::ROW_FILL);
        v_main_end = v_main && r_s2_ctl.last;
        v_tail     = r_s2_valid && !r_s2_ctl.first && (r_s2_ctl.kind == ibbl_pkg::ROW_BOTTOM);
        v_tail_end = v_tail && r_s2_ctl.last;

        // only orders that occur: main, main+end, main+tail, main+end+tail+end
        push.entry[0] = '{pixel: main_pix, eol: 1'b0, eof: 1'b0, last: 1'b0};
        if (v_main_end) begin
            push.entry[1] = '{pixel: end_pix, eol: 1'b1,
                              eof: (r_s2_ctl.kind == ibbl_pkg::ROW_HORIZ) && r_s2_ctl.last_row,
                              last: 1'b0};
        end else begin
            push.entry[1] = '{pixel: ot, eol: 1'b0, eof: 1'b0, last: 1'b0};
        end
        push.entry[2] = '{pixel: ot, eol: 1'b0, eof: 1'b0, last: 1'b0};
        push.entry[3] = '{pixel: r_s2_x, eol: 1'b1, eof: 1'b1, last: 1'b0};
        push.count = ibbl_pkg::PUSH_CNT_W'(v_main) + ibbl_pkg::PUSH_CNT_W'(v_main_end)
                   + ibbl_pkg::PUSH_CNT_W'(v_tail) + ibbl_pkg::PUSH_CNT_W'(v_tail_end);
        for (int i = 0; i < ibbl_pkg::MAX_RESULTS; i++) begin
            push.entry[i].last = (ibbl_pkg::PUSH_CNT_W'(i) ==
                                  push.count - ibbl_pkg::PUSH_CNT_W'(1));
        end

        // output of column k-1 goes to the above line at once, the line end in the cycle after
        main_we = v_main && keeps_line;
        if (r_dw_valid) begin
            o_ao_we    = 1'b1;
            o_ao_waddr = r_dw_addr;
            o_ao_wdata = r_dw_data;
        end else begin
            o_ao_we    = main_we;
            o_ao_waddr = r_s2_col - ADDR_W'(1);
            o_ao_wdata = main_pix;
        end

        // a write that lands on the entry being read this edge
        n_byp_valid = i_accept && o_ao_we && (o_ao_waddr == i_col);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_dw_valid  <= 1'b0;
            r_byp_valid <= 1'b0;
        end else begin
            r_s1_valid  <= i_accept;
            r_s2_valid  <= r_s1_valid;
            r_dw_valid  <= v_main_end && keeps_line;
            r_byp_valid <= n_byp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_data <= o_ao_wdata;
        if (i_accept) begin
            r_s1_ctl   <= i_ctl;
            r_s1_col   <= i_col;
            r_s1_x     <= i_pixel;
            r_s1_prev  <= r_x1;
            r_s1_prev2 <= r_x2;
            r_x1       <= i_pixel;
            r_x2       <= r_x1;
        end
        if (r_s1_valid) begin
            r_a2      <= r_a1;
            r_a1      <= a0;
            r_p1      <= i_pi_rdata;
            r_s2_ctl  <= r_s1_ctl;
            r_s2_col  <= r_s1_col;
            r_s2_x    <= r_s1_x;
            r_s2_prev <= r_s1_prev;
            r_s2_p0   <= i_pi_rdata;
            r_s2_p1   <= r_p1;
            r_s2_sum9 <= n_sum9;
            r_s2_sum3 <= n_sum3;
        end
        if (v_main) begin
            r_left <= main_pix;
        end
        if (v_tail) begin
            r_tail <= ot;
        end
        r_dw_addr <= r_s2_col;
        r_dw_data <= end_pix;
    end

    assign o_push            = push;
    assign o_status.s1_valid = r_s1_valid;
    assign o_status.s2_valid = r_s2_valid;

endmodule

[rtl/ibbl_result_fifo.sv]
// result queue: takes up to four words a cycle, gives one while the reader is ready
`timescale 1ns / 1ps

module ibbl_result_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ibbl_pkg::t_push               i_push,
    input  logic                          i_ready,
    output logic                          o_valid,
    output ibbl_pkg::t_result             o_head,
    output logic [ibbl_pkg::FIFO_CNT_W-1:0] o_count
);

    ibbl_pkg::t_result                r_mem [ibbl_pkg::FIFO_DEPTH];
    logic [ibbl_pkg::FIFO_PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [ibbl_pkg::FIFO_CNT_W-1:0]  r_count;
    logic                             pop;

    assign pop = (r_count != '0) && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + ibbl_pkg::FIFO_PTR_W'(i_push.count);
            r_rd_ptr <= r_rd_ptr + ibbl_pkg::FIFO_PTR_W'(pop);
            r_count  <= r_count + ibbl_pkg::FIFO_CNT_W'(i_push.count)
                      - ibbl_pkg::FIFO_CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ibbl_pkg::MAX_RESULTS; i++) begin
            if (ibbl_pkg::PUSH_CNT_W'(i) < i_push.count) begin
                r_mem[r_wr_ptr + ibbl_pkg::FIFO_PTR_W'(i)] <= i_push.entry[i];
            end
        end
    end

    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

[rtl/inplace_box_blur_luma.sv]
// top level of the streaming in-place luma box blur (1x3 and 3x3)
`timescale 1ns / 1ps

// Streaming luma box blur with in-place semantics: each output is a truncated
// box average in which the already blurred left neighbour (and in 3x3 mode the
// already blurred line above) stands in for the raw sample. Pixels enter in
// raster order, one word per clock, and results leave in raster order through
// a 16-word queue at up to one word per clock. An input word may cause 0 to 4
// results; an input is taken whenever the queue has room for the worst case of
// every word still in the 2-stage pipe, so with a draining sink the block runs
// at one pixel per clock except on the last line of a 3x3 frame, where two
// results per pixel make the sink set the pace. The rate is set by the left
// neighbour recurrence in the last stage (one add and one reciprocal multiply
// per clock) and by the single read and write port of each line memory. Two
// line memories of MAX_WIDTH bytes hold the blurred line above and the raw
// line pending; they need no clearing after reset, as every frame fills them
// before use. Width and height are saturated to 3..MAX_WIDTH and 3..MAX_HEIGHT.
// A write to any defined configuration register restarts the frame at line 0,
// column 0; write only while no results are outstanding.

module inplace_box_blur_luma #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [ibbl_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [ibbl_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input pixels
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [7:0]                        i_pixel_in,
    // results
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [7:0]                        o_pixel_out,
    output logic                              o_end_of_line,
    output logic                              o_end_of_frame,
    output logic                              o_last_of_run
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    // configuration registers
    logic        r_blur_mode;
    logic [11:0] r_frame_width;
    logic [12:0] r_frame_height;

    // raster position
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;

    logic [CW-1:0] last_col;
    logic [RW-1:0] last_row;
    logic          accept;
    logic          cfg_hit;

    ibbl_pkg::t_item_ctl    ctl;
    ibbl_pkg::t_push        push;
    ibbl_pkg::t_pipe_status status;
    ibbl_pkg::t_result      head;
    logic [ibbl_pkg::FIFO_CNT_W-1:0] fifo_count;
    logic [ibbl_pkg::FIFO_CNT_W:0]   reserve;

    logic          ao_we;
    logic [CW-1:0] ao_waddr;
    logic [7:0]    ao_wdata, ao_rdata, pi_rdata;

    // saturated frame size, as last index
    always_comb begin
        if (r_frame_width < 12'd3) begin
            last_col = CW'(2);
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            last_col = CW'(MAX_WIDTH - 1);
        end else begin
            last_col = CW'(r_frame_width - 12'd1);
        end
        if (r_frame_height < 13'd3) begin
            last_row = RW'(2);
        end else if (32'(r_frame_height) > MAX_HEIGHT) begin
            last_row = RW'(MAX_HEIGHT - 1);
        end else begin
            last_row = RW'(r_frame_height - 13'd1);
        end
    end

    // room for the worst case of this word and every word in flight
    always_comb begin
        reserve = (ibbl_pkg::FIFO_CNT_W + 1)'(fifo_count)
                + (ibbl_pkg::FIFO_CNT_W + 1)'(ibbl_pkg::MAX_RESULTS)
                  * (ibbl_pkg::FIFO_CNT_W + 1)'(status.s1_valid)
                + (ibbl_pkg::FIFO_CNT_W + 1)'(ibbl_pkg::MAX_RESULTS)
                  * (ibbl_pkg::FIFO_CNT_W + 1)'(status.s2_valid);
        o_in_ready = reserve <= (ibbl_pkg::FIFO_CNT_W + 1)'(ibbl_pkg::FIFO_DEPTH
                                                          - ibbl_pkg::MAX_RESULTS);
    end

    assign accept = i_in_valid && o_in_ready;

    // a write to a defined register restarts the frame
    assign cfg_hit = i_cfg_we && (i_cfg_index inside {ibbl_pkg::CFG_BLUR_MODE,
                                                      ibbl_pkg::CFG_FRAME_WIDTH,
                                                      ibbl_pkg::CFG_FRAME_HEIGHT});

    // what the current line does with this word
    always_comb begin
        if (!r_blur_mode) begin
            ctl.kind = ibbl_pkg::ROW_HORIZ;
        end else if (r_row == '0) begin
            ctl.kind = ibbl_pkg::ROW_TOP;
        end else if (r_row == RW'(1)) begin
            ctl.kind = ibbl_pkg::ROW_FILL;
        end else if (r_row == last_row) begin
            ctl.kind = ibbl_pkg::ROW_BOTTOM;
        end else begin
            ctl.kind = ibbl_pkg::ROW_MID;
        end
        ctl.first    = (r_col == '0);
        ctl.second   = (r_col == CW'(1));
        ctl.last     = (r_col == last_col);
        ctl.last_row = (r_row == last_row);
    end

    // configuration writes and raster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blur_mode    <= 1'b0;
            r_frame_width  <= ibbl_pkg::RESET_FRAME_WIDTH;
            r_frame_height <= ibbl_pkg::RESET_FRAME_HEIGHT;
            r_col          <= '0;
            r_row          <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ibbl_pkg::CFG_BLUR_MODE: begin
                        r_blur_mode <= i_cfg_data[0];
                    end
                    ibbl_pkg::CFG_FRAME_WIDTH: begin
                        r_frame_width <= i_cfg_data[11:0];
                    end
                    ibbl_pkg::CFG_FRAME_HEIGHT: begin
                        r_frame_height <= i_cfg_data[12:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (cfg_hit) begin
                // restart the frame
                r_col <= '0;
                r_row <= '0;
            end else if (accept) begin
                if (r_col == last_col) begin
                    r_col <= '0;
                    r_row <= (r_row == last_row) ? '0 : r_row + RW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
        end
    end

    // blurred line above, indexed by column
    ibbl_line_ram #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (8)
    ) u_above_line (
        .i_clk   (i_clk),
        .i_we    (ao_we),
        .i_waddr (ao_waddr),
        .i_wdata (ao_wdata),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (ao_rdata)
    );

    // raw line pending, replaced column by column as the next line arrives
    ibbl_line_ram #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (8)
    ) u_pending_line (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_col),
        .i_wdata (i_pixel_in),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (pi_rdata)
    );

    ibbl_blur_core #(
        .ADDR_W (CW)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_ctl      (ctl),
        .i_col      (r_col),
        .i_pixel    (i_pixel_in),
        .i_ao_rdata (ao_rdata),
        .i_pi_rdata (pi_rdata),
        .o_ao_we    (ao_we),
        .o_ao_waddr (ao_waddr),
        .o_ao_wdata (ao_wdata),
        .o_push     (push),
        .o_status   (status)
    );

    ibbl_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_head  (head),
        .o_count (fifo_count)
    );

    assign o_pixel_out    = head.pixel;
    assign o_end_of_line  = head.eol;
    assign o_end_of_frame = head.eof;
    assign o_last_of_run  = head.last;

endmodule

[tb/tb_top.sv]
// self-checking testbench for the in-place luma box blur in 1x3 and 3x3 modes
`timescale 1ns / 1ps

module tb_top;

    localparam int FRAME_W_MAX     = 2048;
    localparam int FRAME_H_MAX     = 4096;
    localparam int RESET_CYCLES    = 10;
    // pipe is 2 deep; a word that makes no result may still be in flight
    localparam int SETTLE_CYCLES   = 12;
    localparam int HOLD_OFF_CYCLES = 300;
    // random words including the backpressure phase
    localparam int RANDOM_PIXELS   = 150;
    // words sent into each saturated-size frame, lines left open
    localparam int BIG_PIXELS      = 12;
    localparam int MAX_REPORTS     = 10;
    localparam int CYCLE_LIMIT     = 1000000;

    // index past the three defined registers, writes to it must be ignored
    localparam logic [ibbl_pkg::CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    // expected-value model of the blur plus the queue of blurred words still owed
    class blur_checker;
        logic        mode;
        logic [11:0] width_reg;
        logic [12:0] height_reg;
        logic [7:0]  above_line [FRAME_W_MAX];
        logic [7:0]  pending_line [FRAME_W_MAX];
        logic [7:0]  window [3];
        logic [7:0]  left_out;
        logic [7:0]  tail_left;
        int          col;
        int          row;
        ibbl_pkg::t_result fresh [$];
        ibbl_pkg::t_result due [$];
        int          failures;
        int          checked;
        int          frames_done;

        function new();
            mode       = 1'b0;
            width_reg  = ibbl_pkg::RESET_FRAME_WIDTH;
            height_reg = ibbl_pkg::RESET_FRAME_HEIGHT;
            foreach (above_line[i]) begin
                above_line[i]   = 8'd0;
                pending_line[i] = 8'd0;
            end
            foreach (window[i]) window[i] = 8'd0;
            left_out    = 8'd0;
            tail_left   = 8'd0;
            col         = 0;
            row         = 0;
            failures    = 0;
            checked     = 0;
            frames_done = 0;
        endfunction

        function void emit(logic [7:0] pix, logic eol, logic eof);
            ibbl_pkg::t_result r;
            r.pixel = pix;
            r.eol   = eol;
            r.eof   = eof;
            r.last  = 1'b0;
            fresh.push_back(r);
        endfunction

        // any defined register restarts the frame
        function void configure(logic [ibbl_pkg::CFG_INDEX_W-1:0] index,
                                logic [ibbl_pkg::CFG_DATA_W-1:0] data);
            case (index)
                ibbl_pkg::CFG_BLUR_MODE:    mode = data[0];
                ibbl_pkg::CFG_FRAME_WIDTH:  width_reg = data[11:0];
                ibbl_pkg::CFG_FRAME_HEIGHT: height_reg = data[12:0];
                default:                    return;
            endcase
            col = 0;
            row = 0;
        endfunction

        // 1x3 rule: column k-1 finishes when column k arrives, last column follows
        function void line_rule(int k, int w, logic [7:0] prev, logic [7:0] x,
                                bit for_tail, bit eof_line, bit keep);
            int         o;
            logic [7:0] lft;
            if (k == 0) return;
            lft = for_tail ? tail_left : left_out;
            if (k == 1) o = prev;
            else o = (int'(lft) + int'(prev) + int'(x)) / 3;
            if (for_tail) tail_left = 8'(o);
            else left_out = 8'(o);
            emit(8'(o), 1'b0, 1'b0);
            if (keep) above_line[k-1] = 8'(o);
            if (k == w - 1) begin
                emit(x, 1'b1, eof_line);
                if (keep) above_line[k] = x;
            end
        endfunction

        // 3x3 rule for the line above while this line arrives
        function void window_rule(int k, int w, logic [7:0] x);
            int         j;
            int         o;
            int         s;
            logic [7:0] e;
            if (k == 0) return;
            j = k - 1;
            if (j == 0) begin
                o = pending_line[0];
            end else begin
                s = int'(above_line[j-1]) + int'(above_line[j]) + int'(above_line[j+1])
                  + int'(left_out) + int'(pending_line[j]) + int'(pending_line[j+1])
                  + int'(window[1]) + int'(window[2]) + int'(x);
                o = s / 9;
                above_line[j-1] = left_out;
            end
            left_out        = 8'(o);
            pending_line[j] = window[2];
            emit(8'(o), 1'b0, 1'b0);
            if (k == w - 1) begin
                e               = pending_line[k];
                above_line[k-1] = left_out;
                above_line[k]   = e;
                pending_line[k] = x;
                emit(e, 1'b1, 1'b0);
            end
        endfunction

        // one accepted pixel word: work out every blurred word it releases
        function void take_pixel(logic [7:0] x);
            int         w;
            int         h;
            int         k;
            int         r;
            logic [7:0] prev;
            w = width_reg;
            if (w < 3) w = 3;
            if (w > FRAME_W_MAX) w = FRAME_W_MAX;
            h = height_reg;
            if (h < 3) h = 3;
            if (h > FRAME_H_MAX) h = FRAME_H_MAX;
            fresh.delete();
            if (col >= w) col = 0;
            if (row >= h) row = 0;
            k    = col;
            r    = row;
            prev = window[2];
            if (!mode) begin
                line_rule(k, w, prev, x, 1'b0, r == h - 1, 1'b0);
            end else if (r == 0) begin
                line_rule(k, w, prev, x, 1'b0, 1'b0, 1'b1);
            end else if (r == 1) begin
                pending_line[k] = x;
            end else begin
                window_rule(k, w, x);
                if (r == h - 1) line_rule(k, w, prev, x, 1'b1, 1'b1, 1'b0);
            end
            window[0] = window[1];
            window[1] = window[2];
            window[2] = x;
            if (k == w - 1) begin
                col = 0;
                row = (r == h - 1) ? 0 : r + 1;
            end else begin
                col = k + 1;
            end
            if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
            foreach (fresh[i]) due.push_back(fresh[i]);
        endfunction

        function void check_blurred(logic [7:0] pix, logic eol, logic eof, logic last);
            ibbl_pkg::t_result want;
            checked++;
            if (eof) frames_done++;
            if (due.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("unexpected blurred word %0d: pixel %0d eol %0b eof %0b last %0b",
                             checked, pix, eol, eof, last);
                return;
            end
            want = due.pop_front();
            if (want.pixel !== pix || want.eol !== eol || want.eof !== eof
                    || want.last !== last) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display({"blurred word %0d: expected pixel %0d eol %0b eof %0b last %0b,",
                              " got pixel %0d eol %0b eof %0b last %0b"},
                             checked, want.pixel, want.eol, want.eof, want.last,
                             pix, eol, eof, last);
            end
        endfunction
    endclass

    // block inputs, all known from time zero
    logic                             i_clk     = 1'b0;
    logic                             i_rst_n   = 1'b0;
    logic                             cfg_we    = 1'b0;
    logic [ibbl_pkg::CFG_INDEX_W-1:0] cfg_index = ibbl_pkg::CFG_BLUR_MODE;
    logic [ibbl_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                             in_valid  = 1'b0;
    logic [7:0]                       in_pixel  = 8'd0;
    logic                             out_ready = 1'b0;

    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_pixel_out;
    logic       o_end_of_line;
    logic       o_end_of_frame;
    logic       o_last_of_run;

    blur_checker board = new();

    // idling percentages, set per phase by the stimulus
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    // raised by the stimulus, taken and counted out by the sink
    bit hold_off_req   = 1'b0;
    int phase_no       = 0;
    int pixels_sent    = 0;
    int cycle_count    = 0;

    inplace_box_blur_luma i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_pixel_in     (in_pixel),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_pixel_out    (o_pixel_out),
        .o_end_of_line  (o_end_of_line),
        .o_end_of_frame (o_end_of_frame),
        .o_last_of_run  (o_last_of_run)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // random pixel with the two extremes over-weighted
    function automatic logic [7:0] any_pixel();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    // offer one pixel word, after a random gap, and hold it until taken;
    // valid is left high so back-to-back words need no second assignment
    task automatic send_pixel(input logic [7:0] pix);
        int gap;
        gap = 0;
        while (gap < 16 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_pixel <= pix;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.take_pixel(pix);
        pixels_sent++;
    endtask

    // register write; bits above the register's width carry random junk.
    // write enable is left high, the caller drops it after the last write
    task automatic write_reg(input logic [ibbl_pkg::CFG_INDEX_W-1:0] index, input int value,
                             input int bits);
        logic [ibbl_pkg::CFG_DATA_W-1:0] keep_mask;
        logic [ibbl_pkg::CFG_DATA_W-1:0] data;
        keep_mask = ibbl_pkg::CFG_DATA_W'((1 << bits) - 1);
        data      = (ibbl_pkg::CFG_DATA_W'($urandom) & ~keep_mask)
                  | (ibbl_pkg::CFG_DATA_W'(value) & keep_mask);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge i_clk);
        board.configure(index, data);
    endtask

    // stop offering, wait until every owed word is out and the pipe is empty
    task automatic settle();
        in_valid <= 1'b0;
        while (board.due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // new settings on an idle block, idling profile rotates with each phase
    task automatic begin_phase(input logic mode, input int width_raw, input int height_raw);
        settle();
        case (t_idle_mode'(phase_no % 4))
            IDLE_NONE: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER: begin
                send_idle_pct  = 50;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct  = 0;
                recv_stall_pct = 50;
            end
            default: begin
                send_idle_pct  = 28;
                recv_stall_pct = 28;
            end
        endcase
        write_reg(ibbl_pkg::CFG_BLUR_MODE, mode, 1);
        write_reg(ibbl_pkg::CFG_FRAME_WIDTH, width_raw, 12);
        write_reg(ibbl_pkg::CFG_FRAME_HEIGHT, height_raw, 13);
        cfg_we <= 1'b0;
        phase_no++;
    endtask

    // sink: random stalls, plus one long hold-off counted out here
    initial begin : sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_left    = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // every accepted blurred word goes against the oldest owed one
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready)
            board.check_blurred(o_pixel_out, o_end_of_line, o_end_of_frame, o_last_of_run);
    end

    initial begin : stimulus
        logic [7:0] probe_pixels [12];
        int         n;
        int         rand_pixels;
        int         w_raw;
        int         h_raw;
        int         w_eff;
        int         h_eff;
        int         count;
        logic       mode_pick;

        probe_pixels = '{8'd255, 8'd0, 8'd255, 8'd1, 8'd254, 8'd0,
                         8'd128, 8'd127, 8'd85, 8'd170, 8'd255, 8'd255};
        rand_pixels = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings (1x3, 640 wide): a few words into line 0, left open
        for (n = 0; n < 4; n++) send_pixel(probe_pixels[n]);

        // width 1 and height 0 saturate to 3x3; the write also restarts the
        // frame left open above; one whole 1x3 frame with extreme values
        begin_phase(1'b0, 1, 0);
        for (n = 0; n < 9; n++) send_pixel(probe_pixels[n]);

        // 3x3 on 4x3: top line 1x3, second line only stored, last line
        // interleaves the middle and bottom results, four words on the final pixel.
        // a write to the spare index halfway must not restart the frame
        begin_phase(1'b1, 4, 3);
        for (n = 0; n < 6; n++) send_pixel(probe_pixels[n]);
        settle();
        write_reg(CFG_SPARE, 0, 0);
        cfg_we <= 1'b0;
        for (n = 6; n < 12; n++) send_pixel(probe_pixels[n]);

        // backpressure: sink holds off for a long stretch while words keep
        // coming, so the result queue fills and the input stalls
        begin_phase(1'b1, 5, 6);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_req   = 1'b1;
        repeat (60) send_pixel(any_pixel());
        rand_pixels += 60;

        // random small frames, mostly whole, some cut short by the next write
        while (rand_pixels < RANDOM_PIXELS) begin
            mode_pick = 1'($urandom_range(0, 1));
            w_raw     = $urandom_range(0, 9);
            h_raw     = $urandom_range(0, 6);
            w_eff     = (w_raw < 3) ? 3 : w_raw;
            h_eff     = (h_raw < 3) ? 3 : h_raw;
            count     = w_eff * h_eff * $urandom_range(1, 2);
            if ($urandom_range(0, 4) == 0) count = $urandom_range(1, w_eff * h_eff - 1);
            begin_phase(mode_pick, w_raw, h_raw);
            repeat (count) send_pixel(any_pixel());
            rand_pixels += count;
        end

        // largest sizes, first line left open: width 4095 saturates to the
        // full line store
        begin_phase(1'b0, 4095, 3);
        repeat (BIG_PIXELS) send_pixel(any_pixel());
        begin_phase(1'b1, FRAME_W_MAX, 3);
        repeat (BIG_PIXELS) send_pixel(any_pixel());
        // height 8191 saturates to the tallest frame, width 2 to short lines
        begin_phase(1'b1, 2, 8191);
        repeat (BIG_PIXELS) send_pixel(any_pixel());

        settle();
        $display("covered %0d pixel words over %0d settings: 1x3 and 3x3 frames up to 9x6,",
                 pixels_sent, phase_no + 1);
        $display("saturated sizes, mid-frame restarts; %0d words checked, %0d frames ended",
                 board.checked, board.frames_done);
        if (board.failures == 0 && board.due.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d words still owed", cycle_count, board.due.size());
        $display("tb_top failed");
        $finish;
    end

endmodule

[inplace_box_blur_luma.f]
rtl/ibbl_pkg.sv
rtl/ibbl_line_ram.sv
rtl/ibbl_blur_core.sv
rtl/ibbl_result_fifo.sv
rtl/inplace_box_blur_luma.sv
tb/tb_top.sv
